[design/srd_pkg.sv]
package srd_pkg;

    // Output fields are fixed at 11 bits for positions and lengths.
    localparam int FIELD_W = 11;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [FIELD_W-1:0] start_pixel;
        logic [FIELD_W-1:0] run_length;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [7:0]         alpha;
        logic               frame_done;
    } result_t;

    // Up to two results per parsed byte: a run or pixel, then the frame fill.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[design/srd_ifs.sv]
interface srd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srd_pixel_if;
    logic        valid;
    logic        ready;
    logic [10:0] start_pixel;
    logic [10:0] run_length;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic        frame_done;

    modport source (output valid, output start_pixel, output run_length, output blue,
                    output green, output red, output alpha, output frame_done,
                    input ready);
    modport sink (input valid, input start_pixel, input run_length, input blue,
                  input green, input red, input alpha, input frame_done,
                  output ready);
endinterface

interface srd_cfg_if;
    logic valid;
    logic ready;
    logic has_alpha;

    modport source (output valid, output has_alpha, input ready);
    modport sink (input valid, input has_alpha, output ready);
endinterface

[design/srd_parser.sv]
module srd_parser #(
    parameter int FRAME_PIXELS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          has_alpha,
    srd_byte_if.sink      stream,
    input  logic          room_ok,
    output srd_pkg::push_t push
);
    import srd_pkg::*;

    localparam int POS_W = $clog2(FRAME_PIXELS + 1);
    localparam int CNT_W = 16;
    localparam logic [POS_W-1:0] FRAME_POS = POS_W'(FRAME_PIXELS);

    localparam logic [2:0] PH_TLO = 3'd0;
    localparam logic [2:0] PH_THI = 3'd1;
    localparam logic [2:0] PH_CLO = 3'd2;
    localparam logic [2:0] PH_CHI = 3'd3;
    localparam logic [2:0] PH_RED = 3'd4;
    localparam logic [2:0] PH_GRN = 3'd5;
    localparam logic [2:0] PH_BLU = 3'd6;
    localparam logic [2:0] PH_ALP = 3'd7;

    // input word register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       count_low_reg, count_low_next;
    logic [CNT_W-1:0] colored_left_reg, colored_left_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg, blue_next;
    logic [POS_W-1:0] wp_reg, wp_next;

    result_t main_r, fill_r;
    logic    main_v, fill_v;

    assign take         = in_valid_reg && room_ok;
    assign stream.ready = !in_valid_reg || take;
    assign in_valid_next = stream.ready ? stream.valid : in_valid_reg;

    always_comb
    begin
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] left_dec;
        logic [CNT_W-1:0] room16;
        logic [CNT_W-1:0] len16;
        logic [POS_W-1:0] room;
        logic [7:0]       px_blue;
        logic [7:0]       px_alpha;
        logic             emit;

        phase_next        = phase_reg;
        count_low_next    = count_low_reg;
        colored_left_next = colored_left_reg;
        red_next          = red_reg;
        green_next        = green_reg;
        blue_next         = blue_reg;
        wp_next           = wp_reg;
        main_v            = 1'b0;
        main_r            = '0;
        fill_v            = 1'b0;
        fill_r            = '0;
        emit              = 1'b0;
        px_blue           = data_reg;
        px_alpha          = ALPHA_OPAQUE;
        cnt               = {data_reg, count_low_reg};
        left_dec          = colored_left_reg - CNT_W'(1);
        room              = FRAME_POS - wp_reg;
        room16            = CNT_W'(room);
        len16             = (cnt < room16) ? cnt : room16;

        if (take)
        begin
            // bytes after a full frame are dropped until the last one
            if (wp_reg != FRAME_POS)
            begin
                case (phase_reg)
                    PH_TLO:
                    begin
                        count_low_next = data_reg;
                        phase_next     = PH_THI;
                    end
                    PH_THI:
                    begin
                        if (len16 != '0)
                        begin
                            main_v             = 1'b1;
                            main_r.start_pixel = FIELD_W'(wp_reg);
                            main_r.run_length  = FIELD_W'(len16);
                            main_r.alpha       = ALPHA_CLEAR;
                            wp_next            = wp_reg + POS_W'(len16);
                        end
                        phase_next = PH_CLO;
                    end
                    PH_CLO:
                    begin
                        count_low_next = data_reg;
                        phase_next     = PH_CHI;
                    end
                    PH_CHI:
                    begin
                        colored_left_next = cnt;
                        phase_next        = (cnt != '0) ? PH_RED : PH_TLO;
                    end
                    PH_RED:
                    begin
                        red_next   = data_reg;
                        phase_next = PH_GRN;
                    end
                    PH_GRN:
                    begin
                        green_next = data_reg;
                        phase_next = PH_BLU;
                    end
                    PH_BLU:
                    begin
                        blue_next = data_reg;
                        if (has_alpha)
                            phase_next = PH_ALP;
                        else
                            emit = 1'b1;
                    end
                    default:
                    begin
                        px_blue  = blue_reg;
                        px_alpha = data_reg;
                        emit     = 1'b1;
                    end
                endcase
            end

            if (emit)
            begin
                main_v             = 1'b1;
                main_r.start_pixel = FIELD_W'(wp_reg);
                main_r.run_length  = FIELD_W'(1);
                main_r.blue        = px_blue;
                main_r.green       = green_reg;
                main_r.red         = red_reg;
                main_r.alpha       = px_alpha;
                wp_next            = wp_reg + POS_W'(1);
                colored_left_next  = left_dec;
                phase_next         = (left_dec != '0) ? PH_RED : PH_TLO;
            end

            // last byte: fill the remainder and start a fresh sprite
            if (last_reg)
            begin
                fill_v             = 1'b1;
                fill_r.start_pixel = FIELD_W'(wp_next);
                fill_r.run_length  = FIELD_W'(FRAME_POS - wp_next);
                fill_r.alpha       = ALPHA_CLEAR;
                fill_r.frame_done  = 1'b1;
                phase_next         = PH_TLO;
                count_low_next     = '0;
                colored_left_next  = '0;
                red_next           = '0;
                green_next         = '0;
                blue_next          = '0;
                wp_next            = '0;
            end
        end
    end

    assign push.count  = {1'b0, main_v} + {1'b0, fill_v};
    assign push.first  = main_v ? main_r : fill_r;
    assign push.second = fill_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_TLO;
            count_low_reg    <= '0;
            colored_left_reg <= '0;
            red_reg          <= '0;
            green_reg        <= '0;
            blue_reg         <= '0;
            wp_reg           <= '0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            phase_reg        <= phase_next;
            count_low_reg    <= count_low_next;
            colored_left_reg <= colored_left_next;
            red_reg          <= red_next;
            green_reg        <= green_next;
            blue_reg         <= blue_next;
            wp_reg           <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready)
        begin
            data_reg <= stream.data_byte;
            last_reg <= stream.last_byte;
        end
    end

endmodule

[design/srd_out_queue.sv]
module srd_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  srd_pkg::push_t push,
    output logic           room_ok,
    srd_pixel_if.source    pixels
);
    import srd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    result_t          head;

    assign head    = slot_reg[rd_reg];
    assign pop     = pixels.valid && pixels.ready;
    // room for a two-result burst
    assign room_ok = cnt_reg <= CNT_W'(DEPTH - 2);

    assign wr_next  = wr_reg + PTR_W'(push.count);
    assign rd_next  = rd_reg + PTR_W'(pop);
    assign cnt_next = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);

    assign pixels.valid       = cnt_reg != '0;
    assign pixels.start_pixel = head.start_pixel;
    assign pixels.run_length  = head.run_length;
    assign pixels.blue        = head.blue;
    assign pixels.green       = head.green;
    assign pixels.red         = head.red;
    assign pixels.alpha       = head.alpha;
    assign pixels.frame_done  = head.frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            slot_reg[wr_reg + PTR_W'(1)] <= push.second;
    end

endmodule

[design/sprite_rle_to_bgra_decoder.sv]
// Run-length sprite decoder, BGRA pixel writes out.
//
// stream : compressed sprite bytes (data_byte, last_byte), valid/ready.
// pixels : one word per write: start_pixel, run_length, BGRA, frame_done.
//          Transparent runs carry all-zero color; colored pixels are
//          single-pixel writes. The final word of a sprite fills the rest
//          of the frame (run_length 0 if already full) with frame_done set.
// cfg    : has_alpha; ready is always high. Write only while idle.
//
// Throughput: one byte per cycle while the queue has room. A byte lands in
// the input register, is parsed from there, and its results enter a 4-word
// output queue. The parse step waits while the queue holds more than two
// words, since the last byte can produce two words (a pixel or run plus
// the fill); those two words leave one per cycle while pixels.ready is high.
// Receiver stalls back up into the queue and then into stream.ready;
// nothing is dropped.
// Reset clears the parse state, write position, has_alpha and the queue.
module sprite_rle_to_bgra_decoder #(
    parameter int FRAME_PIXELS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    srd_byte_if.sink    stream,
    srd_pixel_if.source pixels,
    srd_cfg_if.sink     cfg
);
    import srd_pkg::*;

    logic  has_alpha_reg;
    logic  room_ok;
    push_t push;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            has_alpha_reg <= 1'b0;
        else if (cfg.valid)
            has_alpha_reg <= cfg.has_alpha;
    end

    // byte register, parse state, result generation
    srd_parser #(
        .FRAME_PIXELS(FRAME_PIXELS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .has_alpha(has_alpha_reg),
        .stream   (stream),
        .room_ok  (room_ok),
        .push     (push)
    );

    // result words waiting for the receiver
    srd_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room_ok(room_ok),
        .pixels (pixels)
    );

endmodule

[bench/tb_top.sv]
module tb_top;
    import srd_pkg::*;

    localparam int FRAME = 1024;

    // Parse phases of the compressed stream, in the order the bytes arrive.
    typedef enum logic [2:0] {
        PH_TRANS_LO,
        PH_TRANS_HI,
        PH_COLOR_LO,
        PH_COLOR_HI,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_ALPHA
    } parse_e;

    logic clk;
    logic rst_n;

    srd_byte_if  stream_if ();
    srd_pixel_if pixel_if ();
    srd_cfg_if   cfg_if ();

    sprite_rle_to_bgra_decoder #(
        .FRAME_PIXELS (FRAME)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .pixels (pixel_if),
        .cfg    (cfg_if)
    );

    // ------------------------------------------------------------------
    // Decoder shadow state (mirrors the block's parse state)
    // ------------------------------------------------------------------
    bit          alpha_mode;
    parse_e      phase;
    logic [7:0]  count_lo;
    logic [15:0] colors_left;
    logic [23:0] pixel_acc;      // red 7:0, green 15:8, blue 23:16
    int unsigned write_pos;

    result_t     pending_writes[$];   // words the decoder still owes us
    int unsigned bytes_sent;
    int unsigned mismatches;

    // Idle knobs, percent of cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    logic [7:0]  sprite_bytes[$];

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic void clear_shadow();
        phase       = PH_TRANS_LO;
        count_lo    = '0;
        colors_left = '0;
        pixel_acc   = '0;
        write_pos   = 0;
    endfunction

    function automatic void push_write(input int unsigned start, input int unsigned len,
                                       input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r, input logic [7:0] a,
                                       input logic done);
        result_t w;
        w.start_pixel = start[FIELD_W-1:0];
        w.run_length  = len[FIELD_W-1:0];
        w.blue        = b;
        w.green       = g;
        w.red         = r;
        w.alpha       = a;
        w.frame_done  = done;
        pending_writes.push_back(w);
    endfunction

    // A finished colored pixel: one single-pixel write unless the frame is full.
    function automatic void finish_pixel(input logic [7:0] a);
        if (write_pos < FRAME)
        begin
            push_write(write_pos, 1, pixel_acc[23:16], pixel_acc[15:8], pixel_acc[7:0],
                       a, 1'b0);
            write_pos++;
        end
        pixel_acc   = '0;
        colors_left = colors_left - 16'd1;
        phase       = (colors_left != 0) ? PH_RED : PH_TRANS_LO;
    endfunction

    // Advance the shadow decoder by one accepted byte, queuing the writes it owes.
    function automatic void decode_byte(input logic [7:0] b, input logic is_last);
        int unsigned cnt;
        int unsigned room;
        int unsigned len;
        if (write_pos < FRAME)
        begin
            case (phase)
                PH_TRANS_LO:
                begin
                    count_lo = b;
                    phase    = PH_TRANS_HI;
                end
                PH_TRANS_HI:
                begin
                    cnt  = 32'({b, count_lo});
                    room = FRAME - write_pos;
                    len  = (cnt < room) ? cnt : room;
                    // zero-length transparent run: nothing emitted
                    if (len > 0)
                    begin
                        push_write(write_pos, len, 8'h00, 8'h00, 8'h00, ALPHA_CLEAR, 1'b0);
                        write_pos += len;
                    end
                    phase = PH_COLOR_LO;
                end
                PH_COLOR_LO:
                begin
                    count_lo = b;
                    phase    = PH_COLOR_HI;
                end
                PH_COLOR_HI:
                begin
                    colors_left = {b, count_lo};
                    phase       = (colors_left != 0) ? PH_RED : PH_TRANS_LO;
                end
                PH_RED:
                begin
                    pixel_acc = {16'h0000, b};
                    phase     = PH_GREEN;
                end
                PH_GREEN:
                begin
                    pixel_acc[15:8] = b;
                    phase           = PH_BLUE;
                end
                PH_BLUE:
                begin
                    pixel_acc[23:16] = b;
                    // alpha mode is looked at here, not when the alpha byte comes
                    if (alpha_mode)
                    begin
                        phase = PH_ALPHA;
                    end
                    else
                    begin
                        finish_pixel(ALPHA_OPAQUE);
                    end
                end
                default:
                begin
                    finish_pixel(b);
                end
            endcase
        end
        if (is_last)
        begin
            // fill the rest of the frame; length 0 when already full
            room = (write_pos < FRAME) ? FRAME - write_pos : 0;
            push_write(write_pos, room, 8'h00, 8'h00, 8'h00, ALPHA_CLEAR, 1'b1);
            clear_shadow();
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, initial drive
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n               = 1'b0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = 8'h00;
        stream_if.last_byte = 1'b0;
        pixel_if.ready      = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.has_alpha    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Pixel side: random backpressure and the word checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        pixel_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        string   bad;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            got.start_pixel = pixel_if.start_pixel;
            got.run_length  = pixel_if.run_length;
            got.blue        = pixel_if.blue;
            got.green       = pixel_if.green;
            got.red         = pixel_if.red;
            got.alpha       = pixel_if.alpha;
            got.frame_done  = pixel_if.frame_done;
            if (pending_writes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word start=%0d len=%0d done=%0b",
                                          got.start_pixel, got.run_length, got.frame_done));
            end
            else
            begin
                want = pending_writes.pop_front();
                bad  = "";
                if (got.start_pixel !== want.start_pixel) bad = {bad, " start_pixel"};
                if (got.run_length  !== want.run_length)  bad = {bad, " run_length"};
                if (got.blue        !== want.blue)        bad = {bad, " blue"};
                if (got.green       !== want.green)       bad = {bad, " green"};
                if (got.red         !== want.red)         bad = {bad, " red"};
                if (got.alpha       !== want.alpha)       bad = {bad, " alpha"};
                if (got.frame_done  !== want.frame_done)  bad = {bad, " frame_done"};
                if (bad != "")
                begin
                    report_mismatch($sformatf("word differs in%s: got %h want %h",
                                              bad, got, want));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stream side helpers
    // ------------------------------------------------------------------

    // One byte: optional random idle, then hold valid until ready.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        stream_if.last_byte <= is_last;
        @(posedge clk);
        while (!stream_if.ready)
        begin
            @(posedge clk);
        end
        decode_byte(b, is_last);
        bytes_sent++;
    endtask

    // Send sprite_bytes; last_byte on the final one only if asked.
    task automatic send_sprite(input bit mark_last);
        for (int i = 0; i < sprite_bytes.size(); i++)
        begin
            send_byte(sprite_bytes[i], mark_last && (i == sprite_bytes.size() - 1));
        end
        sprite_bytes.delete();
    endtask

    // Stop sending and wait until every owed word is out, plus slack for
    // bytes that produce nothing but may still sit in the pipe.
    task automatic wait_idle();
        @(negedge clk);
        stream_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_has_alpha(input bit v);
        wait_idle();
        @(negedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.has_alpha <= v;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        alpha_mode = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_count(input logic [15:0] v);
        sprite_bytes.push_back(v[7:0]);
        sprite_bytes.push_back(v[15:8]);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero transparent run, one pixel with FF/55/AA bytes, a run of 0xFFFF
    // clipped at the frame end, then a byte that the full frame ignores.
    task automatic test_extremes();
        add_count(16'h0000);
        add_count(16'h0001);
        sprite_bytes.push_back(8'hFF);
        sprite_bytes.push_back(8'h55);
        sprite_bytes.push_back(8'hAA);
        add_count(16'hFFFF);
        sprite_bytes.push_back(8'h02);
        send_sprite(1'b1);
        wait_idle();
    endtask

    // Colored count of zero, then a stream cut inside a pixel.
    task automatic test_zero_colors_truncated();
        add_count(16'h0003);
        add_count(16'h0000);
        add_count(16'h0005);
        add_count(16'h0001);
        sprite_bytes.push_back(8'h12);
        sprite_bytes.push_back(8'h34);
        send_sprite(1'b1);
        wait_idle();
    endtask

    // Pixel waiting on its alpha byte keeps taking it after alpha mode drops.
    task automatic test_alpha_switch();
        set_has_alpha(1'b1);
        add_count(16'h0000);
        add_count(16'h0001);
        sprite_bytes.push_back(8'h10);
        sprite_bytes.push_back(8'h20);
        sprite_bytes.push_back(8'h30);
        send_sprite(1'b0);
        set_has_alpha(1'b0);
        send_byte(8'h80, 1'b1);
        wait_idle();
    endtask

    // Mostly well-formed sprites with random content; some noise, some cut short.
    task automatic random_sprite();
        int unsigned pairs;
        int unsigned sel;
        logic [15:0] trans_cnt;
        logic [15:0] color_cnt;
        int unsigned npix;
        int unsigned cut;
        if ($urandom_range(9, 0) == 0)
        begin
            repeat ($urandom_range(8, 1)) sprite_bytes.push_back(8'($urandom_range(255, 0)));
        end
        else
        begin
            pairs = $urandom_range(3, 1);
            repeat (pairs)
            begin
                sel = $urandom_range(99, 0);
                if (sel < 10)
                    trans_cnt = 16'h0000;
                else if (sel < 75)
                    trans_cnt = 16'($urandom_range(20, 1));
                else if (sel < 92)
                    trans_cnt = 16'($urandom_range(1100, 900));
                else
                    trans_cnt = 16'($urandom_range(65535, 0));
                add_count(trans_cnt);
                sel = $urandom_range(99, 0);
                if (sel < 20)
                    color_cnt = 16'h0000;
                else if (sel < 95)
                    color_cnt = 16'($urandom_range(3, 1));
                else
                    color_cnt = 16'($urandom_range(65535, 0));   // stream ends early
                add_count(color_cnt);
                npix = (color_cnt > 3) ? 3 : color_cnt;
                repeat (npix)
                begin
                    repeat (alpha_mode ? 4 : 3)
                        sprite_bytes.push_back(8'($urandom_range(255, 0)));
                end
            end
            // truncated stream now and then
            if ($urandom_range(4, 0) == 0)
            begin
                cut = $urandom_range(sprite_bytes.size(), 1);
                while (sprite_bytes.size() > cut)
                begin
                    void'(sprite_bytes.pop_back());
                end
            end
        end
        send_sprite(1'b1);
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input bit alpha_v, input int unsigned n_bytes);
        int unsigned target;
        set_has_alpha(alpha_v);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            random_sprite();
        end
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        alpha_mode     = 1'b0;
        bytes_sent     = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clear_shadow();
        @(posedge rst_n);
        repeat (2) @(posedge clk);

        test_extremes();
        test_zero_colors_truncated();
        test_alpha_switch();

        test_random_phase(0, 0, 1'b1, 15);
        test_random_phase(61, 0, 1'b0, 15);
        test_random_phase(0, 61, 1'b1, 15);
        test_random_phase(18, 18, 1'b0, 15);

        wait_idle();
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hang guard
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/srd_pkg.sv
design/srd_ifs.sv
design/srd_parser.sv
design/srd_out_queue.sv
design/sprite_rle_to_bgra_decoder.sv
bench/tb_top.sv
